// File: rtl/etce_pkg.sv
// ----------------------------------------------------------------------------
// etce_pkg: shared types and constants of the expression tree evaluator
// Number format, operation codes and saturation helpers used by all modules except etce_ram.
// ----------------------------------------------------------------------------
package etce_pkg;

	localparam int MAX_NODES = 64;
	localparam int FRAC_BITS = 24;
	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int VAL_W     = 48;
	localparam int MAG_W     = 44;
	localparam int LINK_W    = 20;
	localparam int OUT_W     = 28;
	localparam int SIZE_W    = 7;

	localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [VAL_W-1:0] VAL_LIM = VAL_W'(64'sd1000000 <<< FRAC_BITS);
	localparam logic signed [VAL_W-1:0] OUT_LIM = VAL_W'(64'sd4 <<< FRAC_BITS);

	// Operation codes.
	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_MUL   = 4'd2;
	localparam logic [3:0] OP_DIV   = 4'd3;
	localparam logic [3:0] OP_MIN   = 4'd4;
	localparam logic [3:0] OP_MAX   = 4'd5;
	localparam logic [3:0] OP_SQR   = 4'd6;
	localparam logic [3:0] OP_ABS   = 4'd7;
	localparam logic [3:0] OP_NEG   = 4'd8;
	localparam logic [3:0] OP_CONST = 4'd9;
	localparam logic [3:0] OP_ERR   = 4'd10;
	localparam logic [3:0] OP_INT   = 4'd11;
	localparam logic [3:0] OP_DER   = 4'd12;
	localparam logic [3:0] OP_PLANT = 4'd13;

	localparam logic MODE_WRITE = 1'b0;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic       start;
		logic [3:0] op;
	} alu_req_t;

	// Clamps a 49-bit signed value to the node value range.
	function automatic logic signed [VAL_W-1:0] sat_node(input logic signed [VAL_W:0] v);
		logic signed [VAL_W:0] lim;
		lim = {VAL_LIM[VAL_W-1], VAL_LIM};
		if (v > lim)
			return VAL_LIM;
		else if (v < -lim)
			return -VAL_LIM;
		else
			return v[VAL_W-1:0];
	endfunction

	// Magnitude of a saturated node value.
	function automatic logic [MAG_W-1:0] mag(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] m;
		m = v[VAL_W-1] ? -v : v;
		return m[MAG_W-1:0];
	endfunction

endpackage

// File: rtl/expression_tree_controller_eval_unit.sv
// ----------------------------------------------------------------------------
// expression_tree_controller_eval_unit: expression tree control law evaluator
// Loads tree nodes and evaluates the stored tree on each sample.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) carries one beat per item. A beat
// with mode 0 writes one node into the node memories and gives no result.
// A beat with mode 1 brings the four control samples and produces exactly
// one control_value beat on the output channel (out_valid/out_stall).
// tree_size is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block idles, as the block itself does not enforce this.
// An evaluation walks the nodes from tree_size-1 down to the root, node 0;
// multiply and square use the digit-serial multiplier, division by a nonzero
// value the restoring divider at one quotient bit per cycle. An empty or
// oversized tree, or a root with an invalid operation code, answers zero
// without a walk. One item is in work at a time; in_stall is high while an
// evaluation runs. A finished result waits in the output register while the
// receiver stalls, and the next item is still accepted; a later result waits
// until that register is free. Reset clears the control state and tree_size;
// the node memories keep their contents undefined until written.
module expression_tree_controller_eval_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [etce_pkg::SIZE_W-1:0]         cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [5:0]                          node_index,
	input  logic [3:0]                          node_op,
	input  logic signed [7:0]                   left_child,
	input  logic signed [7:0]                   right_child,
	input  logic signed [etce_pkg::VAL_W-1:0]   const_value,
	input  logic signed [etce_pkg::VAL_W-1:0]   error_in,
	input  logic signed [etce_pkg::VAL_W-1:0]   integral_in,
	input  logic signed [etce_pkg::VAL_W-1:0]   deriv_in,
	input  logic signed [etce_pkg::VAL_W-1:0]   plant_out,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [etce_pkg::OUT_W-1:0]   control_value
);
	import etce_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROOT  = 3'd1;
	localparam logic [2:0] ST_LINK  = 3'd2;
	localparam logic [2:0] ST_CHILD = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]              state_q;
	logic [SIZE_W-1:0]       size_q;
	logic [NODE_AW-1:0]      idx_q;
	logic signed [VAL_W-1:0] err_q, int_q, der_q, plant_q;
	logic signed [VAL_W-1:0] res_q;
	logic [LINK_W-1:0]       link_q;

	logic                    accept;
	logic [NODE_AW-1:0]      link_rd_addr;
	logic [LINK_W-1:0]       link_rd;
	logic [VAL_W-1:0]        const_rd;
	logic [VAL_W-1:0]        left_rd, right_rd;
	logic                    val_we;
	logic [VAL_W-1:0]        alu_value;
	logic                    alu_done;
	alu_req_t                alu_req;
	logic signed [7:0]       l_idx, r_idx;
	logic                    l_ok, r_ok;
	logic signed [VAL_W-1:0] opd_a, opd_b;
	logic                    out_free;
	logic signed [VAL_W-1:0] clamped;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	// Child decoding from the link word of the current node.
	assign l_idx = link_q[11:4];
	assign r_idx = link_q[19:12];
	assign l_ok  = !l_idx[7] && ({1'b0, l_idx[6:0]} < {1'b0, size_q});
	assign r_ok  = !r_idx[7] && ({1'b0, r_idx[6:0]} < {1'b0, size_q});

	// Operand selection for the arithmetic unit.
	always_comb begin
		opd_b = r_ok ? $signed(right_rd) : '0;
		case (link_q[3:0])
			OP_CONST: opd_a = $signed(const_rd);
			OP_ERR:   opd_a = err_q;
			OP_INT:   opd_a = int_q;
			OP_DER:   opd_a = der_q;
			OP_PLANT: opd_a = plant_q;
			OP_DIV: begin
				opd_a = l_ok ? $signed(left_rd) : '0;
				opd_b = r_ok ? $signed(right_rd) : VAL_ONE;
			end
			default:  opd_a = l_ok ? $signed(left_rd) : '0;
		endcase
	end

	assign alu_req.start = (state_q == ST_CHILD);
	assign alu_req.op    = link_q[3:0];
	assign val_we        = (state_q == ST_EXEC) && alu_done;

	// The link address runs one node ahead so that the link word is ready in ST_LINK.
	assign link_rd_addr  = (state_q == ST_ROOT) ? NODE_AW'(size_q - 1'b1) :
	                       (state_q == ST_EXEC && alu_done) ? idx_q - 1'b1 :
	                       (state_q == ST_IDLE) ? '0 : idx_q;

	assign clamped = ($signed(alu_value) > OUT_LIM) ? OUT_LIM :
	                 ($signed(alu_value) < -OUT_LIM) ? -OUT_LIM : $signed(alu_value);

	// Node link memory: operation and child indexes.
	etce_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_links (
		.clk     (clk),
		.wr_en   (accept && mode == MODE_WRITE),
		.wr_addr (node_index),
		.wr_data ({right_child, left_child, node_op}),
		.rd_addr (link_rd_addr),
		.rd_data (link_rd)
	);

	// Node constant memory.
	etce_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_consts (
		.clk     (clk),
		.wr_en   (accept && mode == MODE_WRITE),
		.wr_addr (node_index),
		.wr_data (const_value),
		.rd_addr (link_rd_addr),
		.rd_data (const_rd)
	);

	// Two copies of the node value memory, one per child read.
	etce_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_vals_l (
		.clk     (clk),
		.wr_en   (val_we),
		.wr_addr (idx_q),
		.wr_data (alu_value),
		.rd_addr (link_rd[4 +: NODE_AW]),
		.rd_data (left_rd)
	);

	etce_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_vals_r (
		.clk     (clk),
		.wr_en   (val_we),
		.wr_addr (idx_q),
		.wr_data (alu_value),
		.rd_addr (link_rd[12 +: NODE_AW]),
		.rd_data (right_rd)
	);

	etce_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (opd_a),
		.b      (opd_b),
		.done   (alu_done),
		.value  (alu_value)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= '0;
		else if (cfg_wr_en)
			size_q <= cfg_wr_data;
	end

	// Sample capture, saturated as leaf values, and capture of the current link word.
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q   <= sat_node({error_in[VAL_W-1], error_in});
			int_q   <= sat_node({integral_in[VAL_W-1], integral_in});
			der_q   <= sat_node({deriv_in[VAL_W-1], deriv_in});
			plant_q <= sat_node({plant_out[VAL_W-1], plant_out});
		end
		if (state_q == ST_LINK)
			link_q <= link_rd;
	end

	// Tree walk sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode != MODE_WRITE) begin
						res_q <= '0;
						if (size_q == '0 || size_q > SIZE_W'(MAX_NODES))
							state_q <= ST_FIN;
						else
							state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					idx_q <= NODE_AW'(size_q - 1'b1);
					if (link_rd[3:0] > OP_PLANT)
						state_q <= ST_FIN;
					else
						state_q <= ST_LINK;
				end
				ST_LINK:  state_q <= ST_CHILD;
				ST_CHILD: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (alu_done) begin
						if (idx_q == '0) begin
							res_q   <= clamped;
							state_q <= ST_FIN;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= ST_LINK;
						end
					end
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free)
			control_value <= res_q[OUT_W-1:0];
	end

endmodule

// File: rtl/etce_ram.sv
// ----------------------------------------------------------------------------
// etce_ram: generic single-clock RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module etce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/etce_alu.sv
// ----------------------------------------------------------------------------
// etce_alu: node arithmetic unit
// Non-iterative simple operations, a digit-serial multiplier and a restoring
// divider; every result is saturated to the node value range.
// ----------------------------------------------------------------------------
module etce_alu (
	input  logic                              clk,
	input  logic                              arst_n,
	input  etce_pkg::alu_req_t                req,
	input  logic signed [etce_pkg::VAL_W-1:0] a,
	input  logic signed [etce_pkg::VAL_W-1:0] b,
	output logic                              done,
	output logic signed [etce_pkg::VAL_W-1:0] value
);
	import etce_pkg::*;

	localparam int DIG_W   = 16;
	localparam int NUM_W   = MAG_W + FRAC_BITS;
	localparam int ACC_W   = 2 * MAG_W + 1;
	localparam int CNT_W   = $clog2(NUM_W + 1);
	localparam int MUL_END = 4;

	logic                   busy_q;
	logic                   is_div_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [MAG_W-1:0]       x_q;
	logic [VAL_W-1:0]       y_q;
	logic [MAG_W+DIG_W-1:0] prod_q;
	logic [ACC_W-1:0]       acc_q;
	logic [NUM_W-1:0]       num_q;
	logic [MAG_W-1:0]       den_q;
	logic [MAG_W:0]         rem_q;
	logic [NUM_W-1:0]       quo_q;

	logic signed [VAL_W:0]  a_x, b_x;
	logic signed [VAL_W-1:0] simple_v;
	logic [MAG_W:0]         rem_sh;
	logic [ACC_W-1:0]       acc_rnd;
	logic [ACC_W-1:0]       m_val;
	logic [VAL_W-1:0]       m_sat;
	logic signed [VAL_W-1:0] fin_v;

	assign a_x = {a[VAL_W-1], a};
	assign b_x = {b[VAL_W-1], b};

	// Operations that need no iteration.
	always_comb begin
		case (req.op) inside
			OP_ADD:   simple_v = sat_node(a_x + b_x);
			OP_SUB:   simple_v = sat_node(a_x - b_x);
			OP_MIN:   simple_v = (a < b) ? a : b;
			OP_MAX:   simple_v = (a > b) ? a : b;
			OP_ABS:   simple_v = sat_node(a_x[VAL_W] ? -a_x : a_x);
			OP_NEG:   simple_v = sat_node(-a_x);
			OP_DIV:   simple_v = VAL_ONE;
			OP_CONST, OP_ERR, OP_INT, OP_DER, OP_PLANT:
				simple_v = sat_node(a_x);
			default:  simple_v = '0;
		endcase
	end

	// Divider step and final saturation of the iterative results.
	assign rem_sh  = {rem_q[MAG_W-1:0], num_q[NUM_W-1]};
	assign acc_rnd = acc_q + (ACC_W'(1) << (FRAC_BITS - 1));
	assign m_val   = is_div_q ? ACC_W'(quo_q) : (acc_rnd >> FRAC_BITS);
	assign m_sat   = (m_val > ACC_W'(VAL_LIM)) ? VAL_LIM : m_val[VAL_W-1:0];
	assign fin_v   = neg_q ? -$signed(m_sat) : $signed(m_sat);

	// Control of the iterative unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.op == OP_MUL || req.op == OP_SQR ||
				    (req.op == OP_DIV && b != '0))
					busy_q <= 1'b1;
				else
					done <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if ((is_div_q && cnt_q == CNT_W'(NUM_W)) ||
				    (!is_div_q && cnt_q == CNT_W'(MUL_END))) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath of the multiplier and divider.
	always_ff @(posedge clk) begin
		if (req.start) begin
			value    <= simple_v;
			is_div_q <= (req.op == OP_DIV);
			neg_q    <= (req.op == OP_SQR) ? 1'b0 : (a[VAL_W-1] != b[VAL_W-1]);
			x_q      <= mag(a);
			y_q      <= VAL_W'(mag((req.op == OP_SQR) ? a : b));
			acc_q    <= '0;
			num_q    <= {mag(a), FRAC_BITS'(0)};
			den_q    <= mag(b);
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (busy_q) begin
			if (is_div_q) begin
				if (cnt_q < CNT_W'(NUM_W)) begin
					num_q <= num_q << 1;
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= rem_sh - {1'b0, den_q};
						quo_q <= {quo_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[NUM_W-2:0], 1'b0};
					end
				end else begin
					value <= fin_v;
				end
			end else begin
				if (cnt_q < CNT_W'(MUL_END - 1))
					prod_q <= x_q * y_q[cnt_q[1:0]*DIG_W +: DIG_W];
				if (cnt_q >= CNT_W'(1) && cnt_q < CNT_W'(MUL_END))
					acc_q <= acc_q + (ACC_W'(prod_q) << ((cnt_q[1:0] - 2'd1) * DIG_W));
				if (cnt_q == CNT_W'(MUL_END))
					value <= fin_v;
			end
		end
	end

endmodule

// File: rtl/etce_checker.sv
// ----------------------------------------------------------------------------
// etce_checker: port-level checks of the evaluator
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module etce_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              mode,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [etce_pkg::OUT_W-1:0] control_value
);
	import etce_pkg::*;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(control_value))
		else $error("stalled result beat changed");

	// Results lie within plus or minus four.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (control_value <= OUT_W'(OUT_LIM)) &&
		              (control_value >= -$signed(OUT_W'(OUT_LIM))))
		else $error("result outside clamp range");

	// A node write never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_WRITE && !out_valid |=> !out_valid)
		else $error("result after node write");

	// When a result appears the block is ready for the next item.
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input stalled as result appeared");

endmodule

bind expression_tree_controller_eval_unit etce_checker u_etce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.mode          (mode),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.control_value (control_value)
);
